>>> rtl/crs_pkg.sv
// ---------------------------------------------------------------------------
// crs_pkg: shared types and constants for the spline evaluator
// Payload structs, sequencer states, status codes and fixed-point helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package crs_pkg;

   localparam int COORD_W = 16;
   localparam int ALPHA_W = 17;
   localparam int FRAC_W  = 16;
   localparam int T_W     = 17;
   localparam int COEF_W  = 20;
   localparam int MUL_A_W = 21;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 40;
   localparam int RND_SHIFT = 17;
   localparam int PCNT_W  = 7;
   localparam int STAT_W  = 2;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
   localparam logic signed [COORD_W-1:0] COORD_HALF = 16'sd8192;
   localparam logic [2*T_W-1:0] FRAC_HALF = 34'h0_0000_8000;
   localparam logic signed [ACC_W-1:0] ACC_HALF      = 40'sd65536;
   localparam logic signed [ACC_W-1:0] ACC_COORD_MAX = 40'sd32767;
   localparam logic signed [ACC_W-1:0] ACC_COORD_MIN = -40'sd32768;

   localparam logic [STAT_W-1:0] ST_STORED   = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_EVAL     = 2'd2;
   localparam logic [STAT_W-1:0] ST_EVAL_SAT = 2'd3;

   localparam logic MODE_ADD = 1'b0;

   typedef struct packed {
      logic                       mode;
      logic signed [COORD_W-1:0]  coord_x;
      logic signed [COORD_W-1:0]  coord_y;
      logic [ALPHA_W-1:0]         alpha;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]          status;
      logic signed [COORD_W-1:0]  out_x;
      logic signed [COORD_W-1:0]  out_y;
      logic [PCNT_W-1:0]          point_count;
   } rsp_type;

   typedef struct packed {
      logic                       sat;
      logic signed [COORD_W-1:0]  val;
   } sat_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ADD   = 7'b0000010,
      S_SCALE = 7'b0000100,
      S_ONE   = 7'b0001000,
      S_INDEX = 7'b0010000,
      S_CALC  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   // Round a Q.32 square or cube product back to Q.16, half up.
   function automatic logic [T_W-1:0] round_frac(input logic [2*T_W-1:0] p);
      logic [2*T_W-1:0] s;
      s = p + FRAC_HALF;
      return s[FRAC_W +: T_W];
   endfunction

   function automatic logic signed [COEF_W-1:0] coef_b(
      input logic signed [COORD_W-1:0] p0,
      input logic signed [COORD_W-1:0] p2);
      return COEF_W'(p2) - COEF_W'(p0);
   endfunction

   // 2P0 - 5P1 + 4P2 - P3
   function automatic logic signed [COEF_W-1:0] coef_c(
      input logic signed [COORD_W-1:0] p0,
      input logic signed [COORD_W-1:0] p1,
      input logic signed [COORD_W-1:0] p2,
      input logic signed [COORD_W-1:0] p3);
      logic signed [COEF_W-1:0] e0, e1, e2, e3;
      e0 = COEF_W'(p0);
      e1 = COEF_W'(p1);
      e2 = COEF_W'(p2);
      e3 = COEF_W'(p3);
      return (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
   endfunction

   // -P0 + 3P1 - 3P2 + P3
   function automatic logic signed [COEF_W-1:0] coef_d(
      input logic signed [COORD_W-1:0] p0,
      input logic signed [COORD_W-1:0] p1,
      input logic signed [COORD_W-1:0] p2,
      input logic signed [COORD_W-1:0] p3);
      logic signed [COEF_W-1:0] e0, e1, e2, e3;
      e0 = COEF_W'(p0);
      e1 = COEF_W'(p1);
      e2 = COEF_W'(p2);
      e3 = COEF_W'(p3);
      return ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
   endfunction

   // floor((S + 2^16) / 2^17), then clip to the coordinate range
   function automatic sat_type round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] r;
      sat_type res;
      r = (acc + ACC_HALF) >>> RND_SHIFT;
      if (r > ACC_COORD_MAX) begin
         res.sat = 1'b1;
         res.val = ACC_COORD_MAX[COORD_W-1:0];
      end else if (r < ACC_COORD_MIN) begin
         res.sat = 1'b1;
         res.val = ACC_COORD_MIN[COORD_W-1:0];
      end else begin
         res.sat = 1'b0;
         res.val = r[COORD_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/crs_point_mem.sv
// ---------------------------------------------------------------------------
// crs_point_mem: control point store
// One write port, one registered read port; x in the low half, y in the high.
// ---------------------------------------------------------------------------
`default_nettype none

module crs_point_mem
   import crs_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [2*COORD_W-1:0]  wr_data,
   input  wire logic [AW-1:0]         rd_addr,
   output logic      [2*COORD_W-1:0]  rd_data_ff
);

   logic [2*COORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/crs_mul.sv
// ---------------------------------------------------------------------------
// crs_mul: shared signed multiplier
// Registered product; every multiply of the evaluator goes through here.
// ---------------------------------------------------------------------------
`default_nettype none

module crs_mul
   import crs_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic signed [MUL_A_W-1:0]   op_a,
   input  wire logic signed [MUL_B_W-1:0]   op_b,
   output logic      signed [PROD_W-1:0]    prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
   end

endmodule

`default_nettype wire

>>> rtl/catmull_rom_spline_eval.sv
// ---------------------------------------------------------------------------
// catmull_rom_spline_eval: uniform Catmull-Rom spline evaluator
// Point table with append items and curve evaluation at a Q1.16 parameter.
// ---------------------------------------------------------------------------
// Each request either appends a control point (mode 0) or evaluates the
// curve through the stored points at alpha (mode 1); every request returns
// exactly one response carrying a status, the evaluated x and y (zero for
// appends) and the point count after the request. The block works on one
// request at a time: req_stall is low only while it is idle. An append
// goes through S_ADD and S_DONE to its response. An evaluation over two
// or more points goes from transfer to response through one multiply to
// scale alpha, the segment pick, then 14 sequencer steps in which the
// four point reads share the single memory read port and the square,
// cube and six coefficient products share the single registered
// multiplier. An empty table answers (0.5, 0.5) and a single point
// answers itself. A finished response sits in the output register until
// taken, and the next request is accepted meanwhile. The point store has
// no reset; only entries that were appended are read.
// ---------------------------------------------------------------------------
`default_nettype none

module catmull_rom_spline_eval
   import crs_pkg::*;
#(
   parameter int MAX_POINTS = 64
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire req_type  req_data,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   localparam int CW = $clog2(MAX_POINTS + 1);   // count width, holds MAX_POINTS
   localparam int AW = $clog2(MAX_POINTS);       // store address width

   // sequencer steps inside S_CALC
   localparam logic [3:0] STEP_RD0   = 4'd0;   // read P0, start T*T
   localparam logic [3:0] STEP_RD1   = 4'd1;   // read P1, take t2
   localparam logic [3:0] STEP_RD2   = 4'd2;   // read P2, start t2*T
   localparam logic [3:0] STEP_RD3   = 4'd3;   // read P3, take t3
   localparam logic [3:0] STEP_P3    = 4'd4;   // capture P3
   localparam logic [3:0] STEP_COEF  = 4'd5;   // coefficients, seed sums
   localparam logic [3:0] STEP_MBX   = 4'd6;
   localparam logic [3:0] STEP_MCX   = 4'd7;
   localparam logic [3:0] STEP_MDX   = 4'd8;
   localparam logic [3:0] STEP_MBY   = 4'd9;
   localparam logic [3:0] STEP_MCY   = 4'd10;
   localparam logic [3:0] STEP_MDY   = 4'd11;
   localparam logic [3:0] STEP_ACCY  = 4'd12;  // last y product
   localparam logic [3:0] STEP_ROUND = 4'd13;

   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic [CW-1:0] count_ff, count_in;

   req_type req_ff, req_in;
   logic [ALPHA_W-1:0] al_ff, al_in;
   logic [CW-1:0] i0_ff, i0_in, i1_ff, i1_in, i2_ff, i2_in, i3_ff, i3_in;
   logic [T_W-1:0] t_ff, t_in, t2_ff, t2_in, t3_ff, t3_in;
   logic [2*COORD_W-1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic signed [COEF_W-1:0] bx_ff, bx_in, cx_ff, cx_in, dx_ff, dx_in;
   logic signed [COEF_W-1:0] by_ff, by_in, cy_ff, cy_in, dy_ff, dy_in;
   logic signed [ACC_W-1:0] accx_ff, accx_in, accy_ff, accy_in;
   rsp_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // store and multiplier hookup
   logic                      mem_wr_en;
   logic [AW-1:0]             mem_wr_addr;
   logic [2*COORD_W-1:0]      mem_wr_data;
   logic [AW-1:0]             mem_rd_addr;
   logic [2*COORD_W-1:0]      mem_rd_data;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   // segment pick helpers
   logic [CW-1:0] i1_raw, nm1, nm2, i1_sel, i3_next;
   logic          seg_clamp;
   sat_type       rsx, rsy;

   crs_point_mem #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   crs_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Segment index from the scaled alpha. Clamping only happens at alpha = 1,
   // where the low half is zero and the fraction becomes exactly one.
   assign nm1       = count_ff - CW'(1);
   assign nm2       = count_ff - CW'(2);
   assign i1_raw    = prod[FRAC_W +: CW];
   assign seg_clamp = (i1_raw > nm2);
   assign i1_sel    = seg_clamp ? nm2 : i1_raw;
   assign i3_next   = i1_sel + CW'(2);

   assign rsx = round_sat(accx_ff);
   assign rsy = round_sat(accy_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      al_in        = al_ff;
      i0_in        = i0_ff;
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      i3_in        = i3_ff;
      t_in         = t_ff;
      t2_in        = t2_ff;
      t3_in        = t3_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      p3_in        = p3_ff;
      bx_in        = bx_ff;
      cx_in        = cx_ff;
      dx_in        = dx_ff;
      by_in        = by_ff;
      cy_in        = cy_ff;
      dy_in        = dy_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      mem_wr_en    = 1'b0;
      mem_wr_addr  = count_ff[AW-1:0];
      mem_wr_data  = {req_ff.coord_y, req_ff.coord_x};
      mem_rd_addr  = '0;
      mul_a        = '0;
      mul_b        = '0;

      // drop the output register once the consumer takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               // alpha above one saturates to one
               al_in  = (req_data.alpha > ALPHA_ONE) ? ALPHA_ONE : req_data.alpha;
               state_in = (req_data.mode == MODE_ADD) ? S_ADD : S_SCALE;
            end
         end

         S_ADD: begin
            res_in.out_x = '0;
            res_in.out_y = '0;
            if (count_ff < CW'(MAX_POINTS)) begin
               mem_wr_en          = 1'b1;
               count_in           = count_ff + CW'(1);
               res_in.status      = ST_STORED;
               res_in.point_count = PCNT_W'(count_ff + CW'(1));
            end else begin
               res_in.status      = ST_FULL;
               res_in.point_count = PCNT_W'(count_ff);
            end
            state_in = S_DONE;
         end

         S_SCALE: begin
            // scale alpha by count-1; read entry zero for the single point case
            mul_a       = signed'(MUL_A_W'(nm1));
            mul_b       = signed'(MUL_B_W'(al_ff));
            mem_rd_addr = '0;
            res_in.point_count = PCNT_W'(count_ff);
            res_in.status      = ST_EVAL;
            if (count_ff == '0) begin
               res_in.out_x = COORD_HALF;
               res_in.out_y = COORD_HALF;
               state_in     = S_DONE;
            end else if (count_ff == CW'(1)) begin
               state_in = S_ONE;
            end else begin
               state_in = S_INDEX;
            end
         end

         S_ONE: begin
            res_in.out_x = signed'(mem_rd_data[COORD_W-1:0]);
            res_in.out_y = signed'(mem_rd_data[2*COORD_W-1:COORD_W]);
            state_in     = S_DONE;
         end

         S_INDEX: begin
            i1_in    = i1_sel;
            i0_in    = (i1_sel == '0) ? '0 : i1_sel - CW'(1);
            i2_in    = i1_sel + CW'(1);
            i3_in    = (i3_next < count_ff) ? i3_next : nm1;
            t_in     = {seg_clamp, prod[FRAC_W-1:0]};
            step_in  = STEP_RD0;
            state_in = S_CALC;
         end

         S_CALC: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               STEP_RD0: begin
                  mem_rd_addr = i0_ff[AW-1:0];
                  mul_a = signed'(MUL_A_W'(t_ff));
                  mul_b = signed'(MUL_B_W'(t_ff));
               end
               STEP_RD1: begin
                  mem_rd_addr = i1_ff[AW-1:0];
                  p0_in = mem_rd_data;
                  t2_in = round_frac(prod[2*T_W-1:0]);
               end
               STEP_RD2: begin
                  mem_rd_addr = i2_ff[AW-1:0];
                  p1_in = mem_rd_data;
                  mul_a = signed'(MUL_A_W'(t2_ff));
                  mul_b = signed'(MUL_B_W'(t_ff));
               end
               STEP_RD3: begin
                  mem_rd_addr = i3_ff[AW-1:0];
                  p2_in = mem_rd_data;
                  t3_in = round_frac(prod[2*T_W-1:0]);
               end
               STEP_P3: begin
                  p3_in = mem_rd_data;
               end
               STEP_COEF: begin
                  bx_in = coef_b(signed'(p0_ff[COORD_W-1:0]), signed'(p2_ff[COORD_W-1:0]));
                  cx_in = coef_c(signed'(p0_ff[COORD_W-1:0]), signed'(p1_ff[COORD_W-1:0]),
                                 signed'(p2_ff[COORD_W-1:0]), signed'(p3_ff[COORD_W-1:0]));
                  dx_in = coef_d(signed'(p0_ff[COORD_W-1:0]), signed'(p1_ff[COORD_W-1:0]),
                                 signed'(p2_ff[COORD_W-1:0]), signed'(p3_ff[COORD_W-1:0]));
                  by_in = coef_b(signed'(p0_ff[2*COORD_W-1:COORD_W]),
                                 signed'(p2_ff[2*COORD_W-1:COORD_W]));
                  cy_in = coef_c(signed'(p0_ff[2*COORD_W-1:COORD_W]),
                                 signed'(p1_ff[2*COORD_W-1:COORD_W]),
                                 signed'(p2_ff[2*COORD_W-1:COORD_W]),
                                 signed'(p3_ff[2*COORD_W-1:COORD_W]));
                  dy_in = coef_d(signed'(p0_ff[2*COORD_W-1:COORD_W]),
                                 signed'(p1_ff[2*COORD_W-1:COORD_W]),
                                 signed'(p2_ff[2*COORD_W-1:COORD_W]),
                                 signed'(p3_ff[2*COORD_W-1:COORD_W]));
                  // seed each sum with 2*P1 in Q.16
                  accx_in = ACC_W'(signed'(p1_ff[COORD_W-1:0])) <<< RND_SHIFT;
                  accy_in = ACC_W'(signed'(p1_ff[2*COORD_W-1:COORD_W])) <<< RND_SHIFT;
               end
               STEP_MBX: begin
                  mul_a = MUL_A_W'(bx_ff);
                  mul_b = signed'(MUL_B_W'(t_ff));
               end
               STEP_MCX: begin
                  mul_a   = MUL_A_W'(cx_ff);
                  mul_b   = signed'(MUL_B_W'(t2_ff));
                  accx_in = accx_ff + ACC_W'(prod);
               end
               STEP_MDX: begin
                  mul_a   = MUL_A_W'(dx_ff);
                  mul_b   = signed'(MUL_B_W'(t3_ff));
                  accx_in = accx_ff + ACC_W'(prod);
               end
               STEP_MBY: begin
                  mul_a   = MUL_A_W'(by_ff);
                  mul_b   = signed'(MUL_B_W'(t_ff));
                  accx_in = accx_ff + ACC_W'(prod);
               end
               STEP_MCY: begin
                  mul_a   = MUL_A_W'(cy_ff);
                  mul_b   = signed'(MUL_B_W'(t2_ff));
                  accy_in = accy_ff + ACC_W'(prod);
               end
               STEP_MDY: begin
                  mul_a   = MUL_A_W'(dy_ff);
                  mul_b   = signed'(MUL_B_W'(t3_ff));
                  accy_in = accy_ff + ACC_W'(prod);
               end
               STEP_ACCY: begin
                  accy_in = accy_ff + ACC_W'(prod);
               end
               STEP_ROUND: begin
                  res_in.out_x  = rsx.val;
                  res_in.out_y  = rsy.val;
                  res_in.status = (rsx.sat || rsy.sat) ? ST_EVAL_SAT : ST_EVAL;
                  state_in      = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         S_DONE: begin
            // hold the result until the output register is free or draining
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      al_ff       <= al_in;
      i0_ff       <= i0_in;
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      i3_ff       <= i3_in;
      t_ff        <= t_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      p3_ff       <= p3_in;
      bx_ff       <= bx_in;
      cx_ff       <= cx_in;
      dx_ff       <= dx_in;
      by_ff       <= by_in;
      cy_ff       <= cy_in;
      dy_ff       <= dy_in;
      accx_ff     <= accx_in;
      accy_ff     <= accy_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // table never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count above table depth");

   // the four fetch indices are ordered and inside the table
   a_index_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC) |->
         (i0_ff <= i1_ff && i1_ff < i2_ff && i2_ff <= i3_ff && i3_ff < count_ff))
      else $error("segment indices out of order or outside table");

   // fraction stays within [0,1]
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CALC) |-> (t_ff <= ALPHA_ONE))
      else $error("segment fraction above one");

   // count moves only on an append
   a_count_on_add: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |-> $past(state_ff == S_ADD))
      else $error("point count changed outside an append");

endmodule

`default_nettype wire
